// ===== sv/rlm_pkg.sv =====
package rlm_pkg;

    localparam int BOUND_W = 64;
    localparam int MAX_RANGES_DEF = 16;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_QUERY  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_POST
    } state_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [BOUND_W-1:0] lower_bound;
        logic [BOUND_W-1:0] upper_bound;
        logic [BOUND_W-1:0] probe_value;
    } in_word_t;

    typedef struct packed {
        logic in_list;
        logic status;
    } out_word_t;

endpackage

// ===== sv/range_list_membership_match.sv =====
// Range list membership match. The block holds up to MAX_RANGES inclusive
// 64-bit ranges in a single-port-write, registered-read RAM (low and high bound
// side by side in one word). A clear or append word goes from IDLE to POST,
// which registers its result once the output slot is free and returns to
// IDLE, where the next word can be taken. A query goes from IDLE through
// SCAN, which reads one RAM entry per cycle up to and including the first
// hit or the last stored range, to POST; a query to an empty table skips
// SCAN. A zero bound means no limit on that side, both bounds zero match only
// the value zero, and an empty table matches nothing. Only one word is worked
// on at a time; the result sits in an output register, so a new word is taken
// while the previous result waits.
module range_list_membership_match #(
    parameter int MAX_RANGES = rlm_pkg::MAX_RANGES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  rlm_pkg::in_word_t item,
    output logic              result_valid,
    input  logic              result_ready,
    output rlm_pkg::out_word_t result
);

    import rlm_pkg::*;

    localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CNT_W = $clog2(MAX_RANGES + 1);
    localparam int ENT_W = 2 * BOUND_W;

    function automatic logic range_hit(input logic [BOUND_W-1:0] lo,
                                       input logic [BOUND_W-1:0] hi,
                                       input logic [BOUND_W-1:0] v);
        logic lo_ok;
        logic hi_ok;
        lo_ok = (lo == '0) || (v >= lo);
        hi_ok = (v <= hi) || ((hi == '0) && (lo != '0));
        return lo_ok && hi_ok;
    endfunction

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    logic [BOUND_W-1:0] probe_reg, probe_next;
    logic               pend_in_list_reg, pend_in_list_next;
    logic               pend_status_reg, pend_status_next;
    logic               result_valid_reg, result_valid_next;
    out_word_t          result_reg, result_next;

    logic               item_fire;
    logic               table_full;
    logic               last_entry;
    logic               hit_now;
    logic               slot_free;
    logic               is_query;
    logic               is_append;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENT_W-1:0]   ram_rdata;

    rlm_ram #(
        .WIDTH(ENT_W),
        .DEPTH(MAX_RANGES)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata({item.lower_bound, item.upper_bound}),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign item_fire  = item_valid && item_ready;
    assign is_query   = (item.action == ACT_QUERY);
    assign is_append  = (item.action == ACT_APPEND);
    assign table_full = (count_reg == CNT_W'(MAX_RANGES));
    assign last_entry = ((CNT_W'(chk_idx_reg) + CNT_W'(1)) == count_reg);
    assign hit_now    = range_hit(ram_rdata[ENT_W-1:BOUND_W], ram_rdata[BOUND_W-1:0],
                                  probe_reg);
    assign slot_free  = !result_valid_reg || result_ready;
    assign ram_waddr  = count_reg[IDX_W-1:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    if (is_query && (count_reg != '0))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_POST;
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit_now || last_entry)
                begin
                    state_next = ST_POST;
                end
            end
            ST_POST:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        item_ready = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                ram_we     = item_valid && is_append && !table_full;
                ram_re     = item_valid && is_query;
            end
            ST_SCAN:
            begin
                ram_re    = !hit_now && !last_entry;
                ram_raddr = IDX_W'(chk_idx_reg + IDX_W'(1));
            end
            ST_POST:
            begin
                item_ready = 1'b0;
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        count_next        = count_reg;
        chk_idx_next      = chk_idx_reg;
        probe_next        = probe_reg;
        pend_in_list_next = pend_in_list_reg;
        pend_status_next  = pend_status_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;

        if (item_fire)
        begin
            probe_next        = item.probe_value;
            chk_idx_next      = '0;
            pend_in_list_next = 1'b0;
            pend_status_next  = is_append && table_full;
            if (item.action == ACT_CLEAR)
            begin
                count_next = '0;
            end
            else if (is_append && !table_full)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end

        if (state_reg == ST_SCAN)
        begin
            if (hit_now || last_entry)
            begin
                pend_in_list_next = hit_now;
            end
            else
            begin
                chk_idx_next = IDX_W'(chk_idx_reg + IDX_W'(1));
            end
        end

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end
        if ((state_reg == ST_POST) && slot_free)
        begin
            result_valid_next   = 1'b1;
            result_next.in_list = pend_in_list_reg;
            result_next.status  = pend_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            chk_idx_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            chk_idx_reg      <= chk_idx_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_reg        <= probe_next;
        pend_in_list_reg <= pend_in_list_next;
        pend_status_reg  <= pend_status_next;
        result_reg       <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RANGES))
        else $error("entry count above table size");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (CNT_W'(chk_idx_reg) < count_reg))
        else $error("scan index past the entry count");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && is_append && table_full)
        |=> ((state_reg == ST_POST) && pend_status_reg && $stable(count_reg)))
        else $error("append to a full table was not dropped");

endmodule

// ===== sv/rlm_ram.sv =====
module rlm_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
